@@ design/hme_pkg.sv @@
`timescale 1ns / 1ps

package hme_pkg;

    localparam int WORD_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int GROUP_WORDS = 8;
    localparam int CHUNK_BITS  = GROUP_WORDS - 1;
    localparam int POS_W       = $clog2(GROUP_WORDS);
    localparam int SYN_W       = 6;
    localparam int TOP_BIT     = WORD_W - 1;

    // Parity-check rows; row k supplies syndrome bit SYN_W-1-k.
    localparam logic [WORD_W-1:0] SYN_ROWS [SYN_W] = '{
        64'h0000_0000_FFFF_FFFF,
        64'h0000_FFFF_0000_FFFF,
        64'h00FF_00FF_00FF_00FF,
        64'h0F0F_0F0F_0F0F_0F0F,
        64'h3333_3333_3333_3333,
        64'h5555_5555_5555_5555
    };

    typedef enum logic {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    typedef enum logic {
        RES_STEGO = 1'b0,
        RES_BYTE  = 1'b1
    } res_type_t;

    typedef struct packed {
        logic [WORD_W-1:0] cover_word;
        logic [BYTE_W-1:0] message_byte;
    } hme_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] stego_word;
        logic [BYTE_W-1:0] recovered_byte;
        res_type_t         result_type;
    } hme_out_t;

    // Per-transaction outcome handed from the datapath to the control.
    typedef struct packed {
        logic                  produce;
        logic [POS_W-1:0]      next_pos;
        logic [CHUNK_BITS-1:0] next_carried;
    } hme_step_t;

endpackage

@@ design/hme_syndrome.sv @@
`timescale 1ns / 1ps

module hme_syndrome (
    input  logic [hme_pkg::WORD_W-1:0] word,
    output logic [hme_pkg::SYN_W-1:0]  syn,
    output logic                       par
);
    import hme_pkg::*;

    // Bit 63 has an all-zero column, so the rows never see it.
    always_comb
    begin
        for (int k = 0; k < SYN_W; k++)
        begin
            syn[SYN_W-1-k] = ^(word & SYN_ROWS[k]);
        end
    end

    assign par = ^word;

endmodule

@@ design/hme_core.sv @@
`timescale 1ns / 1ps

module hme_core (
    input  hme_pkg::hme_in_t                 item,
    input  hme_pkg::mode_t                   mode,
    input  logic [hme_pkg::POS_W-1:0]        pos,
    input  logic [hme_pkg::CHUNK_BITS-1:0]   carried,
    output hme_pkg::hme_out_t                result,
    output hme_pkg::hme_step_t               step
);
    import hme_pkg::*;

    localparam int WIDE_W = 2 * CHUNK_BITS;

    logic [SYN_W-1:0]      syn;
    logic                  par;
    logic [BYTE_W-1:0]     b;
    logic [POS_W:0]        sh_b;
    logic [POS_W-1:0]      sh_c;
    logic [WIDE_W-1:0]     carried_wide;
    logic [BYTE_W-1:0]     keep_mask;
    logic [CHUNK_BITS-1:0] embed_chunk;
    logic [CHUNK_BITS-1:0] embed_carry;
    logic [SYN_W-1:0]      v;
    logic                  v_nz;
    logic [WORD_W-1:0]     flipped;
    logic                  par_low;
    logic [CHUNK_BITS-1:0] ext_chunk;
    logic [WIDE_W-1:0]     ext_wide;
    logic [BYTE_W-1:0]     ext_byte;
    logic                  last_pos;

    hme_syndrome u_syn (
        .word (item.cover_word),
        .syn  (syn),
        .par  (par)
    );

    assign last_pos = (pos == POS_W'(GROUP_WORDS - 1));

    // Repack message bytes into chunks; the last word of a group carries no new byte.
    assign b            = last_pos ? '0 : item.message_byte;
    assign sh_b         = {1'b0, pos} + (POS_W+1)'(1);
    assign sh_c         = POS_W'(CHUNK_BITS) - pos;
    assign carried_wide = {{CHUNK_BITS{1'b0}}, carried} << sh_c;
    assign embed_chunk  = CHUNK_BITS'(b >> sh_b) | carried_wide[CHUNK_BITS-1:0];
    assign keep_mask    = ~({BYTE_W{1'b1}} << sh_b);
    assign embed_carry  = CHUNK_BITS'(b & keep_mask);

    // Flip the bit whose column matches the syndrome difference, then fix parity with bit 63.
    assign v       = syn ^ embed_chunk[SYN_W-1:0];
    assign v_nz    = (v != '0);
    assign flipped = {1'b0, item.cover_word[TOP_BIT-1:0]}
                   ^ (v_nz ? (WORD_W'(1) << (~v)) : '0);
    assign par_low = par ^ item.cover_word[TOP_BIT] ^ v_nz;

    assign ext_chunk = {par, syn};
    assign ext_wide  = {{CHUNK_BITS{1'b0}}, carried} << pos;
    assign ext_byte  = ext_wide[BYTE_W-1:0] | BYTE_W'(ext_chunk >> sh_c);

    always_comb
    begin
        if (mode == MODE_EMBED)
        begin
            result.stego_word     = {par_low != embed_chunk[CHUNK_BITS-1],
                                     flipped[TOP_BIT-1:0]};
            result.recovered_byte = '0;
            result.result_type    = RES_STEGO;
            step.produce          = 1'b1;
            step.next_carried     = last_pos ? '0 : embed_carry;
        end
        else
        begin
            result.stego_word     = '0;
            result.recovered_byte = ext_byte;
            result.result_type    = RES_BYTE;
            step.produce          = (pos != '0);
            step.next_carried     = last_pos ? '0 : ext_chunk;
        end
        step.next_pos = pos + POS_W'(1);
    end

endmodule

@@ design/hamming_63_matrix_embedding.sv @@
`timescale 1ns / 1ps

// Matrix embedding with a (63,57) Hamming code over groups of eight 64-bit words.
// Mode 0 hides 7 message bits in each word (seven bytes per group, the eighth
// word's byte is ignored) and returns one stego word per transaction; mode 1
// reads the bits back and returns one byte for every word of a group except the
// first. Writing the mode register restarts the group. Throughput is one word
// per clock: a word waits in the input register while the syndrome XOR trees and
// the repacking shifts settle into the output register. Both registers stall when
// the output is held off.
module hamming_63_matrix_embedding (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hme_pkg::hme_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hme_pkg::hme_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import hme_pkg::*;

    logic                  s1_valid_reg;
    hme_in_t               s1_data_reg;
    mode_t                 mode_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [CHUNK_BITS-1:0] carried_reg;
    logic                  out_valid_reg;
    hme_out_t              out_data_reg;

    hme_out_t              result;
    hme_step_t             step;
    logic                  out_free;
    logic                  s1_go;
    logic                  in_take;
    logic                  cfg_take;

    hme_core u_core (
        .item    (s1_data_reg),
        .mode    (mode_reg),
        .pos     (pos_reg),
        .carried (carried_reg),
        .result  (result),
        .step    (step)
    );

    assign out_free  = !out_valid_reg || out_ready;
    // A first word in extract mode leaves without a result, so it never waits.
    assign s1_go     = s1_valid_reg && (!step.produce || out_free);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_EMBED;
            pos_reg       <= '0;
            carried_reg   <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && step.produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Restart the group on any mode write.
            if (cfg_take)
            begin
                mode_reg    <= mode_t'(cfg_data);
                pos_reg     <= '0;
                carried_reg <= '0;
            end
            else if (s1_go)
            begin
                pos_reg     <= step.next_pos;
                carried_reg <= step.next_carried;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_go && step.produce)
        begin
            out_data_reg <= result;
        end
    end

endmodule

@@ design/hme_checker.sv @@
`timescale 1ns / 1ps

module hme_assertions (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input hme_pkg::hme_out_t out_data
);
    import hme_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // With the output empty nothing can block the input register.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

    // A result carries one kind of payload; the other field stays zero.
    a_payload_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.result_type == RES_STEGO && out_data.recovered_byte == '0)
                    || (out_data.result_type == RES_BYTE && out_data.stego_word == '0)))
        else $error("result carries mixed payload");

    // With no new transaction and an empty output, the input register drains by next cycle.
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && !out_valid |=> in_ready)
        else $error("input not ready after idle cycle");

endmodule

bind hamming_63_matrix_embedding hme_assertions u_hme_assertions (.*);

@@ dv/hme_checker.sv @@
`timescale 1ns / 1ps

module hme_checker
    import hme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  hme_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  hme_out_t    out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int unsigned mismatch_count,
    output int unsigned awaited_count
);

    // Parity-check rows, row k gives syndrome bit 5-k; bit 63 has no column.
    localparam logic [63:0] CHECK_ROWS [6] = '{
        64'h0000_0000_FFFF_FFFF,
        64'h0000_FFFF_0000_FFFF,
        64'h00FF_00FF_00FF_00FF,
        64'h0F0F_0F0F_0F0F_0F0F,
        64'h3333_3333_3333_3333,
        64'h5555_5555_5555_5555
    };

    mode_t      cur_mode;
    logic [2:0] word_pos;
    logic [6:0] held_chunk;
    hme_out_t   awaited_results [$];

    function automatic logic [5:0] syndrome_of(input logic [63:0] w);
        logic [5:0] s;
        s = '0;
        for (int k = 0; k < 6; k++)
            s[5 - k] = ^(w & CHECK_ROWS[k]);
        return s;
    endfunction

    task automatic absorb_word(input hme_in_t item);
        int          p;
        logic [7:0]  msg;
        logic [6:0]  chunk;
        logic [63:0] word;
        logic [5:0]  flip;
        hme_out_t    res;
        p = word_pos;
        res = '0;
        word = item.cover_word;
        word[63] = 1'b0;
        if (cur_mode == MODE_EMBED) begin
            // the last word of a group carries only the leftover bits
            msg = (p == 7) ? 8'h00 : item.message_byte;
            chunk = 7'((msg >> (p + 1)) | (16'(held_chunk) << (7 - p)));
            held_chunk = 7'(msg & ((1 << (p + 1)) - 1));
            flip = syndrome_of(word) ^ chunk[5:0];
            if (flip != 6'd0)
                word = word ^ (64'd1 << (63 - flip));
            if ((^word) != chunk[6])
                word[63] = 1'b1;
            res.stego_word = word;
            res.result_type = RES_STEGO;
            awaited_results.push_back(res);
        end else begin
            chunk = {^item.cover_word, syndrome_of(word)};
            if (p != 0) begin
                res.recovered_byte = 8'((16'(held_chunk) << p) | (chunk >> (7 - p)));
                res.result_type = RES_BYTE;
                awaited_results.push_back(res);
            end
            held_chunk = chunk;
        end
        if (p == 7) begin
            word_pos = '0;
            held_chunk = '0;
        end else begin
            word_pos = word_pos + 3'd1;
        end
    endtask

    task automatic compare_result(input hme_out_t got);
        hme_out_t want;
        if (awaited_results.size() == 0) begin
            $error("unexpected result: stego_word %h recovered_byte %h result_type %0d",
                   got.stego_word, got.recovered_byte, got.result_type);
            mismatch_count++;
        end else begin
            want = awaited_results.pop_front();
            if (got.stego_word !== want.stego_word) begin
                $error("stego_word: expected %h, got %h", want.stego_word, got.stego_word);
                mismatch_count++;
            end
            if (got.recovered_byte !== want.recovered_byte) begin
                $error("recovered_byte: expected %h, got %h",
                       want.recovered_byte, got.recovered_byte);
                mismatch_count++;
            end
            if (got.result_type !== want.result_type) begin
                $error("result_type: expected %0d, got %0d", want.result_type, got.result_type);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_mode = MODE_EMBED;
            word_pos = '0;
            held_chunk = '0;
            awaited_results.delete();
        end else begin
            // any mode write restarts the group
            if (cfg_valid && cfg_ready) begin
                cur_mode = mode_t'(cfg_data);
                word_pos = '0;
                held_chunk = '0;
            end
            if (in_valid && in_ready)
                absorb_word(in_data);
            if (out_valid && out_ready)
                compare_result(out_data);
        end
        awaited_count = awaited_results.size();
    end

endmodule

@@ dv/hamming_63_matrix_embedding_test.sv @@
`timescale 1ns / 1ps

module hamming_63_matrix_embedding_test;

    import hme_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    hme_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    hme_out_t    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    int unsigned mismatch_count;
    int unsigned awaited_count;
    bit          no_gaps;
    int          holds_asked;
    int          idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hamming_63_matrix_embedding uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hme_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    task automatic send_word(input logic [63:0] word, input logic [7:0] msg);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{cover_word: word, message_byte: msg};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_mode(input mode_t m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop input, wait for every result, then cover an extract word still in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = 64'd1 << $urandom_range(0, 63);
            3: w = ~(64'd1 << $urandom_range(0, 63));
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        int    n;
        mode_t m;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        no_gaps = 1'b0;
        holds_asked = 0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // one full embed group out of reset, extremes of word and byte
        send_word('0, 8'h00);
        send_word('1, 8'hFF);
        send_word(64'h8000_0000_0000_0000, 8'hA5);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 8'h5A);
        send_word(64'h0123_4567_89AB_CDEF, 8'h01);
        send_word(64'hFEDC_BA98_7654_3210, 8'h80);
        send_word('0, 8'hFF);
        send_word('1, 8'hFF);
        // partial group, then restart it by rewriting the same mode
        repeat (3) send_word(random_word(), 8'($urandom));
        settle();
        write_mode(MODE_EMBED);
        repeat (2) send_word(random_word(), 8'($urandom));
        settle();
        // extract: first word gives nothing, then wrap into the next group
        write_mode(MODE_EXTRACT);
        send_word('0, 8'h00);
        send_word('1, 8'hFF);
        send_word(64'h8000_0000_0000_0000, 8'h00);
        send_word(64'h0000_0000_0000_0001, 8'hFF);
        repeat (5) send_word(random_word(), 8'($urandom));

        for (int ph = 0; ph < 10; ph++) begin
            settle();
            if (ph % 2 == 0)
                m = MODE_EMBED;
            else
                m = MODE_EXTRACT;
            write_mode(m);
            no_gaps = (ph == 4) || ($urandom_range(0, 3) == 0);
            n = $urandom_range(50, 80);
            for (int i = 0; i < n; i++) begin
                // hold the output off while input keeps coming
                if (ph == 4 && i == 8)
                    holds_asked++;
                send_word(random_word(), 8'($urandom));
            end
        end
        settle();

        if (mismatch_count == 0 && awaited_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        int gap;
        int holds_done;
        holds_done = 0;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                gap = LONG_HOLD;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ sim.f @@
design/hme_pkg.sv
design/hme_syndrome.sv
design/hme_core.sv
design/hamming_63_matrix_embedding.sv
design/hme_checker.sv
dv/hme_checker.sv
dv/hamming_63_matrix_embedding_test.sv
